[rtl/core/oldest_replace_member_table_core_assert.svh]
// Assertion macros used by the table core file.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef OLDEST_REPLACE_MEMBER_TABLE_CORE_ASSERT_SVH
`define OLDEST_REPLACE_MEMBER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ORTBL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ORTBL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ortbl_pkg.sv]
// ----------------------------------------------------------------------------
// ortbl_pkg
// Shared widths, request codes and control structs of the member table.
// ----------------------------------------------------------------------------
package ortbl_pkg;

    localparam int KIND_W        = 2;
    localparam int ID_W          = 32;
    localparam int TIME_W        = 32;
    localparam int SLOT_W        = 4;
    localparam int DEFAULT_DEPTH = 16;

    localparam int S_TDATA_W = 64;   // member_id, now_time
    localparam int S_TUSER_W = 2;    // kind
    localparam int M_TDATA_W = 8;    // ok, slot, zero pad

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;   // start of a new scan
        logic step;    // one entry arrives from the memory
    } t_scan_ctl;

    // Status from the scan unit back to the sequencer.
    typedef struct packed {
        logic hit;     // a valid entry matched the key
        logic free;    // a free slot was seen
    } t_scan_flag;

endpackage

[rtl/core/oldest_replace_member_table_core.sv]
// ----------------------------------------------------------------------------
// oldest_replace_member_table_core
// Member table with oldest-stamp replacement: insert, remove and query.
// Flow: accept, scan every entry, drain the last read, write back, emit result.
// Scan: reads one memory word per cycle through the single RAM read port; a new
//   item is taken only in idle, once the last result is in the output register.
// Reset: synchronous, clears every valid bit (table empty) and both channels.
// ----------------------------------------------------------------------------
module oldest_replace_member_table_core #(
    parameter int TABLE_DEPTH = ortbl_pkg::DEFAULT_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ortbl_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] member_id, [63:32] now_time
    input  logic [ortbl_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] kind
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ortbl_pkg::M_TDATA_W-1:0] m_tdata   // [0] ok, [4:1] slot, [7:5] zero
);
    import ortbl_pkg::*;

    `include "oldest_replace_member_table_core_assert.svh"

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int WORD_W = ID_W + TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [KIND_W-1:0]      r_kind;
    logic [ID_W-1:0]        r_id;
    logic [TIME_W-1:0]      r_time;
    logic [IDX_W-1:0]       r_addr;       // read address being issued
    logic [IDX_W-1:0]       r_data_idx;   // index of the word now on the RAM output
    logic                   r_data_valid; // valid bit of the word now on the RAM output
    logic                   r_step;       // RAM output holds a scanned word
    logic [TABLE_DEPTH-1:0] r_valid;
    logic                   r_pend_ok;
    logic [SLOT_W-1:0]      r_pend_slot;
    logic                   r_out_valid;
    logic                   r_out_ok;
    logic [SLOT_W-1:0]      r_out_slot;

    logic                   w_s_take;
    logic                   w_m_take;
    logic                   w_we;
    logic [WORD_W-1:0]      w_rdata;
    logic [IDX_W-1:0]       w_victim;
    logic [IDX_W-1:0]       w_hit_idx;
    logic [IDX_W-1:0]       w_free_idx;
    logic [IDX_W-1:0]       w_min_idx;
    t_scan_ctl              w_ctl;
    t_scan_flag             w_flag;

    assign s_tready = (r_state == ST_IDLE);
    assign w_s_take = s_tvalid && s_tready;
    assign w_m_take = r_out_valid && m_tready;

    // Insert goes to the lowest free slot, else to the oldest entry.
    assign w_victim = w_flag.free ? w_free_idx : w_min_idx;
    assign w_we     = (r_state == ST_FINISH) && (r_kind == KIND_INSERT);

    assign w_ctl.clear = w_s_take;
    assign w_ctl.step  = r_step;

    // ------------------------------------------------------------------
    // Entry storage: member and stamp share one word.
    // ------------------------------------------------------------------
    ortbl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_victim),
        .i_wdata ({r_time, r_id}),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    ortbl_scan #(
        .DEPTH (TABLE_DEPTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_idx         (r_data_idx),
        .i_entry_valid (r_data_valid),
        .i_member      (w_rdata[ID_W-1:0]),
        .i_stamp       (w_rdata[WORD_W-1:ID_W]),
        .i_key         (r_id),
        .o_flag        (w_flag),
        .o_hit_idx     (w_hit_idx),
        .o_free_idx    (w_free_idx),
        .o_min_idx     (w_min_idx)
    );

    // ------------------------------------------------------------------
    // Sequencer: accept, scan every entry, write back, hand off result.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_s_take) n_state = ST_SCAN;
            ST_SCAN:   if (r_addr == LAST_IDX) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_FINISH;
            ST_FINISH: n_state = ST_EMIT;
            ST_EMIT:   if (!r_out_valid || m_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // one word comes back the cycle after each read issued in scan
            r_step  <= (r_state == ST_SCAN);

            // Update valid bits once the scan results are final.
            if (r_state == ST_FINISH) begin
                if (r_kind == KIND_INSERT) begin
                    r_valid[w_victim] <= 1'b1;
                end else if (r_kind == KIND_REMOVE && w_flag.hit) begin
                    r_valid[w_hit_idx] <= 1'b0;
                end
            end

            // Drop a taken result, load the next one when the register frees.
            if (w_m_take) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_EMIT && (!r_out_valid || m_tready)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_s_take) begin
            r_kind <= s_tuser[KIND_W-1:0];
            r_id   <= s_tdata[ID_W-1:0];
            r_time <= s_tdata[ID_W +: TIME_W];
            r_addr <= '0;
        end else if (r_state == ST_SCAN && r_addr != LAST_IDX) begin
            r_addr <= r_addr + IDX_W'(1);
        end
        // read the valid bit alongside the RAM word so both line up
        r_data_idx   <= r_addr;
        r_data_valid <= r_valid[r_addr];

        if (r_state == ST_FINISH) begin
            unique case (r_kind)
                KIND_INSERT: begin
                    r_pend_ok   <= 1'b1;
                    r_pend_slot <= SLOT_W'(w_victim);
                end
                KIND_REMOVE, KIND_QUERY: begin
                    r_pend_ok   <= w_flag.hit;
                    r_pend_slot <= w_flag.hit ? SLOT_W'(w_hit_idx) : '0;
                end
                default: begin
                    r_pend_ok   <= 1'b0;
                    r_pend_slot <= '0;
                end
            endcase
        end

        if (r_state == ST_EMIT && (!r_out_valid || m_tready)) begin
            r_out_ok   <= r_pend_ok;
            r_out_slot <= r_pend_slot;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(M_TDATA_W - SLOT_W - 1)'(0), r_out_slot, r_out_ok};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ORTBL_ASSERT_NXT(a_accept_starts_scan, w_s_take,
        (r_state == ST_SCAN) && (r_addr == '0), "accepted item did not start a scan at slot 0")
    `ORTBL_ASSERT_NXT(a_insert_sets_valid, (r_state == ST_FINISH) && (r_kind == KIND_INSERT),
        r_valid[$past(w_victim)], "inserted slot not marked valid")
    `ORTBL_ASSERT_NXT(a_remove_clears_valid,
        (r_state == ST_FINISH) && (r_kind == KIND_REMOVE) && w_flag.hit,
        !r_valid[$past(w_hit_idx)], "removed slot still valid")
    `ORTBL_ASSERT_NOW(a_step_only_when_busy, r_step,
        (r_state == ST_SCAN) || (r_state == ST_DRAIN), "scan step outside of a scan")

endmodule

[rtl/core/ortbl_ram.sv]
// ----------------------------------------------------------------------------
// ortbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ortbl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ortbl_scan.sv]
// ----------------------------------------------------------------------------
// ortbl_scan
// Walks the entries streamed from the table memory and keeps the first match,
// the first free slot and the oldest valid entry.
// ----------------------------------------------------------------------------
module ortbl_scan #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ortbl_pkg::t_scan_ctl         i_ctl,
    input  logic [$clog2(DEPTH)-1:0]     i_idx,
    input  logic                         i_entry_valid,
    input  logic [ortbl_pkg::ID_W-1:0]   i_member,
    input  logic [ortbl_pkg::TIME_W-1:0] i_stamp,
    input  logic [ortbl_pkg::ID_W-1:0]   i_key,
    output ortbl_pkg::t_scan_flag        o_flag,
    output logic [$clog2(DEPTH)-1:0]     o_hit_idx,
    output logic [$clog2(DEPTH)-1:0]     o_free_idx,
    output logic [$clog2(DEPTH)-1:0]     o_min_idx
);
    import ortbl_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic              r_hit;
    logic              r_free;
    logic              r_min_have;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [IDX_W-1:0]  r_free_idx;
    logic [IDX_W-1:0]  r_min_idx;
    logic [TIME_W-1:0] r_min_stamp;
    logic              w_match;
    logic              w_older;

    assign w_match = i_entry_valid && (i_member == i_key);
    assign w_older = i_entry_valid && (!r_min_have || (i_stamp < r_min_stamp));

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_min_have <= 1'b0;
        end else if (i_ctl.step) begin
            if (w_match) begin
                r_hit <= 1'b1;
            end
            if (!i_entry_valid) begin
                r_free <= 1'b1;
            end
            if (i_entry_valid) begin
                r_min_have <= 1'b1;
            end
        end
    end

    // Captured indices and the running oldest stamp.
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (w_match && !r_hit) begin
                r_hit_idx <= i_idx;
            end
            if (!i_entry_valid && !r_free) begin
                r_free_idx <= i_idx;
            end
            // strict compare keeps the lowest slot on a tie
            if (w_older) begin
                r_min_idx   <= i_idx;
                r_min_stamp <= i_stamp;
            end
        end
    end

    assign o_flag.hit  = r_hit;
    assign o_flag.free = r_free;
    assign o_hit_idx   = r_hit_idx;
    assign o_free_idx  = r_free_idx;
    assign o_min_idx   = r_min_idx;

endmodule
